>>> src/tangent_frame_model_matrix_core_defines.svh
// Assertion macros shared by the tangent frame matrix RTL
`ifndef TANGENT_FRAME_MODEL_MATRIX_CORE_DEFINES_SVH
`define TANGENT_FRAME_MODEL_MATRIX_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TFMM_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TFMM_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tfmm_pkg.sv
// Types, constants and helpers for the tangent frame matrix block
`default_nettype none
package tfmm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = 5;
  localparam int SAT_W     = 68;
  localparam logic [31:0] UP_THR = 32'(((95 << FRAC_BITS) + 50) / 100);

  typedef logic signed [31:0] s32_t;

  typedef enum logic [2:0] {
    REG_SCALE  = 3'd0,
    REG_SQUISH = 3'd1,
    REG_CX     = 3'd2,
    REG_CY     = 3'd3,
    REG_CZ     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    s32_t pos_x;
    s32_t pos_y;
    s32_t pos_z;
    s32_t tan_x;
    s32_t tan_y;
    s32_t tan_z;
  } in_item_t;

  typedef struct packed {
    s32_t m_r0_c0;
    s32_t m_r0_c1;
    s32_t m_r0_c2;
    s32_t m_r0_c3;
    s32_t m_r1_c0;
    s32_t m_r1_c1;
    s32_t m_r1_c2;
    s32_t m_r1_c3;
    s32_t m_r2_c0;
    s32_t m_r2_c1;
    s32_t m_r2_c2;
    s32_t m_r2_c3;
  } out_item_t;

  // live configuration seen by the datapath
  typedef struct packed {
    s32_t scale;
    s32_t sz;
    s32_t cx;
    s32_t cy;
    s32_t cz;
  } cfg_t;

  function automatic s32_t sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_W'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < SAT_W'(-64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  // magnitude of a signed word; the most negative value maps to 2^31
  function automatic logic [31:0] mag32(input s32_t x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage
`default_nettype wire

>>> src/tfmm_if.sv
// Valid/ready channel interfaces for the input and result items
`default_nettype none
interface tfmm_in_if import tfmm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfmm_out_if import tfmm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/tangent_frame_model_matrix_core.sv
// Tangent frame model matrix: top level with the full datapath pipeline
//
// Input channel in_chan carries a curve point and a tangent (Q16.16); the
// result channel out_chan carries the upper three rows of the model matrix.
// Both are valid/ready: a transfer happens when valid and ready are high.
// The APB port holds scale, depth squish and the center offset; write it
// only while no item is in flight.
// Throughput: one item per cycle unless the receiver stalls; every stage
// is a register slice. The depth comes from the square root (one result
// bit per stage, 32 stages) and the two normalizing dividers (one
// quotient bit per stage). Each stage holds its item while the next is
// full and stalled, so a receiver stall backs up only as far as the
// filled stages; bubbles close. Reset clears all stage valid bits and
// loads the register defaults (scale and squish 1.0, center 0).
`default_nettype none
`include "tangent_frame_model_matrix_core_defines.svh"
module tangent_frame_model_matrix_core import tfmm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tfmm_in_if.sink                in_chan,
  tfmm_out_if.source             out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int SQ_N  = 32;
  localparam int QB    = FRAC_BITS + 1;
  localparam int Q_W   = FRAC_BITS + 2;
  localparam int PW    = 32 + Q_W;
  localparam int RW    = 32 + FRAC_BITS;
  localparam int PCW   = 64 - FRAC_BITS;
  localparam int LCW   = PCW + 2;
  localparam int S_SQR = 1;
  localparam int S_RAD = 2;
  localparam int S_SQ0 = 3;
  localparam int S_DV0 = S_SQ0 + SQ_N;
  localparam int S_U1  = S_DV0 + QB;
  localparam int S_U2  = S_U1 + 1;
  localparam int S_M1  = S_U2 + 1;
  localparam int S_M2  = S_M1 + 1;
  localparam int S_T1  = S_M2 + 1;
  localparam int S_T2  = S_T1 + 1;
  localparam int NST   = S_T2 + 1;

  cfg_t cfg;

  tfmm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------- pipeline control ----------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] rdy;
  in_item_t       ctx_r [NST];
  logic [NST-1:0] sel_r;
  logic           sel_in;

  assign rdy[NST-1] = !v_r[NST-1] || out_chan.ready;
  for (genvar g = 0; g < NST - 1; g++) begin : g_rdy
    assign rdy[g] = !v_r[g] || rdy[g+1];
  end

  assign in_chan.ready  = rdy[0];
  assign out_chan.valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_chan.valid;
      for (int g = 1; g < NST; g++) begin
        if (rdy[g]) v_r[g] <= v_r[g-1];
      end
    end
  end

  // up vector switches to +X when the tangent is close to +-Y
  assign sel_in = mag32(in_chan.data.tan_y) > UP_THR;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ctx_r[0] <= in_chan.data;
      sel_r[0] <= sel_in;
    end
    for (int g = 1; g < NST; g++) begin
      if (rdy[g]) begin
        ctx_r[g] <= ctx_r[g-1];
        sel_r[g] <= sel_r[g-1];
      end
    end
  end

  // ---------------- squares of the cross components ----------------
  logic [31:0] ma1, mb1;
  logic [63:0] sqa_r, sqb_r;

  assign ma1 = mag32(ctx_r[S_SQR-1].tan_z);
  assign mb1 = sel_r[S_SQR-1] ? mag32(ctx_r[S_SQR-1].tan_y) : mag32(ctx_r[S_SQR-1].tan_x);

  always_ff @(posedge clk) begin
    if (rdy[S_SQR]) begin
      sqa_r <= {32'd0, ma1} * {32'd0, ma1};
      sqb_r <= {32'd0, mb1} * {32'd0, mb1};
    end
  end

  // ---------------- integer square root, one bit per stage ----------------
  logic [63:0] sq_v_r [SQ_N+1];
  logic [63:0] sq_r_r [SQ_N+1];

  always_ff @(posedge clk) begin
    if (rdy[S_RAD]) begin
      sq_v_r[0] <= sqa_r + sqb_r;
      sq_r_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sq_r_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (rdy[S_SQ0+k]) begin
        if (sq_v_r[k] >= trial) begin
          sq_v_r[k+1] <= sq_v_r[k] - trial;
          sq_r_r[k+1] <= (sq_r_r[k] >> 1) + BIT;
        end else begin
          sq_v_r[k+1] <= sq_v_r[k];
          sq_r_r[k+1] <= sq_r_r[k] >> 1;
        end
      end
    end
  end

  // ---------------- normalizing dividers, one quotient bit per stage -------
  logic [RW-1:0] dv_ra_r  [QB];
  logic [RW-1:0] dv_rb_r  [QB];
  logic [QB-1:0] dv_qa_r  [QB];
  logic [QB-1:0] dv_qb_r  [QB];
  logic [31:0]   dv_len_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_dv
    localparam int BI = QB - 1 - j;
    logic [RW-1:0] ra_in, rb_in, dsh;
    logic [QB-1:0] qa_in, qb_in, qa_nxt, qb_nxt;
    logic [31:0]   len_in;
    logic          take_a, take_b;

    if (j == 0) begin : g_init
      logic [31:0] ma0, mb0;
      assign ma0    = mag32(ctx_r[S_DV0-1].tan_z);
      assign mb0    = sel_r[S_DV0-1] ? mag32(ctx_r[S_DV0-1].tan_y)
                                     : mag32(ctx_r[S_DV0-1].tan_x);
      assign ra_in  = RW'(ma0) << FRAC_BITS;
      assign rb_in  = RW'(mb0) << FRAC_BITS;
      assign qa_in  = '0;
      assign qb_in  = '0;
      assign len_in = sq_r_r[SQ_N][31:0];
    end else begin : g_mid
      assign ra_in  = dv_ra_r[j-1];
      assign rb_in  = dv_rb_r[j-1];
      assign qa_in  = dv_qa_r[j-1];
      assign qb_in  = dv_qb_r[j-1];
      assign len_in = dv_len_r[j-1];
    end

    assign dsh    = RW'(len_in) << BI;
    // zero length: both components are zero and the quotient stays zero
    assign take_a = (len_in != '0) && (ra_in >= dsh);
    assign take_b = (len_in != '0) && (rb_in >= dsh);

    always_comb begin
      qa_nxt     = qa_in;
      qb_nxt     = qb_in;
      qa_nxt[BI] = take_a;
      qb_nxt[BI] = take_b;
    end

    always_ff @(posedge clk) begin
      if (rdy[S_DV0+j]) begin
        dv_ra_r[j]  <= take_a ? ra_in - dsh : ra_in;
        dv_rb_r[j]  <= take_b ? rb_in - dsh : rb_in;
        dv_qa_r[j]  <= qa_nxt;
        dv_qb_r[j]  <= qb_nxt;
        dv_len_r[j] <= len_in;
      end
    end
  end

  // ---------------- right vector and products for cUp ----------------
  s32_t tx1, ty1, tz1;
  logic na, nb;
  logic signed [Q_W-1:0] ra_m, rb_m, ra_s, rb_s;
  logic signed [Q_W-1:0] rv [3];
  logic signed [PW-1:0]  pa_r [3];
  logic signed [PW-1:0]  pb_r [3];
  logic signed [PW-1:0]  sr_r [3];

  assign tx1 = ctx_r[S_U1-1].tan_x;
  assign ty1 = ctx_r[S_U1-1].tan_y;
  assign tz1 = ctx_r[S_U1-1].tan_z;

  // sign of the first cross component: -tz when up is +X, tz when up is +Y
  assign na = sel_r[S_U1-1] ? (!tz1[31] && (tz1 != '0)) : tz1[31];
  assign nb = sel_r[S_U1-1] ? ty1[31] : (!tx1[31] && (tx1 != '0));

  assign ra_m = {1'b0, dv_qa_r[QB-1]};
  assign rb_m = {1'b0, dv_qb_r[QB-1]};
  assign ra_s = na ? -ra_m : ra_m;
  assign rb_s = nb ? -rb_m : rb_m;

  assign rv[0] = sel_r[S_U1-1] ? '0 : ra_s;
  assign rv[1] = sel_r[S_U1-1] ? ra_s : '0;
  assign rv[2] = rb_s;

  always_ff @(posedge clk) begin
    if (rdy[S_U1]) begin
      pa_r[0] <= PW'(ty1) * PW'(rv[2]);
      pb_r[0] <= PW'(tz1) * PW'(rv[1]);
      pa_r[1] <= PW'(tz1) * PW'(rv[0]);
      pb_r[1] <= PW'(tx1) * PW'(rv[2]);
      pa_r[2] <= PW'(tx1) * PW'(rv[1]);
      pb_r[2] <= PW'(ty1) * PW'(rv[0]);
      for (int i = 0; i < 3; i++) begin
        sr_r[i] <= PW'(cfg.scale) * PW'(rv[i]);
      end
    end
  end

  // ---------------- cUp and first column ----------------
  logic signed [PW-1:0] ud [3];
  logic signed [PW-1:0] srs [3];
  s32_t u_r [3];
  s32_t m0_r [3];

  for (genvar i = 0; i < 3; i++) begin : g_u
    assign ud[i]  = (pa_r[i] - pb_r[i]) >>> FRAC_BITS;
    assign srs[i] = sr_r[i] >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rdy[S_U2]) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i]  <= sat32(SAT_W'(ud[i]));
        m0_r[i] <= sat32(SAT_W'(srs[i]));
      end
    end
  end

  // ---------------- second and third column products ----------------
  s32_t tv2 [3];
  logic signed [63:0] su_r [3];
  logic signed [63:0] szt_r [3];
  s32_t m0b_r [3];

  assign tv2[0] = ctx_r[S_M1-1].tan_x;
  assign tv2[1] = ctx_r[S_M1-1].tan_y;
  assign tv2[2] = ctx_r[S_M1-1].tan_z;

  always_ff @(posedge clk) begin
    if (rdy[S_M1]) begin
      for (int i = 0; i < 3; i++) begin
        su_r[i]  <= 64'(cfg.scale) * 64'(u_r[i]);
        szt_r[i] <= 64'(cfg.sz) * 64'(tv2[i]);
        m0b_r[i] <= m0_r[i];
      end
    end
  end

  logic signed [63:0] sus [3];
  logic signed [63:0] szts [3];
  s32_t mm_r [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_m
    assign sus[i]  = su_r[i] >>> FRAC_BITS;
    assign szts[i] = szt_r[i] >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rdy[S_M2]) begin
      for (int i = 0; i < 3; i++) begin
        mm_r[i][0] <= m0b_r[i];
        mm_r[i][1] <= sat32(SAT_W'(sus[i]));
        mm_r[i][2] <= sat32(SAT_W'(szts[i]));
      end
    end
  end

  // ---------------- translation: floored products, then the sum ----------------
  s32_t cv [3];
  logic signed [63:0]    cp [3][3];
  logic signed [PCW-1:0] pc_r [3][3];
  s32_t mt_r [3][3];

  assign cv[0] = cfg.cx;
  assign cv[1] = cfg.cy;
  assign cv[2] = cfg.cz;

  for (genvar i = 0; i < 3; i++) begin : g_cr
    for (genvar c = 0; c < 3; c++) begin : g_cc
      assign cp[i][c] = 64'(mm_r[i][c]) * 64'(cv[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_T1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          pc_r[i][c] <= cp[i][c][63:FRAC_BITS];
          mt_r[i][c] <= mm_r[i][c];
        end
      end
    end
  end

  s32_t pv [3];
  logic signed [LCW-1:0] lc [3];
  s32_t tr [3];
  out_item_t out_q_r;

  assign pv[0] = ctx_r[S_T2-1].pos_x;
  assign pv[1] = ctx_r[S_T2-1].pos_y;
  assign pv[2] = ctx_r[S_T2-1].pos_z;

  for (genvar i = 0; i < 3; i++) begin : g_tr
    assign lc[i] = LCW'(pc_r[i][0]) + LCW'(pc_r[i][1]) + LCW'(pc_r[i][2]);
    assign tr[i] = sat32(SAT_W'(pv[i]) - SAT_W'(lc[i]));
  end

  always_ff @(posedge clk) begin
    if (rdy[S_T2]) begin
      out_q_r <= '{
        m_r0_c0: mt_r[0][0], m_r0_c1: mt_r[0][1], m_r0_c2: mt_r[0][2], m_r0_c3: tr[0],
        m_r1_c0: mt_r[1][0], m_r1_c1: mt_r[1][1], m_r1_c2: mt_r[1][2], m_r1_c3: tr[1],
        m_r2_c0: mt_r[2][0], m_r2_c1: mt_r[2][1], m_r2_c2: mt_r[2][2], m_r2_c3: tr[2]
      };
    end
  end

  assign out_chan.data = out_q_r;

  // ---------------- checks ----------------
  `TFMM_AST_NEXT(a_in_lands, in_chan.valid && in_chan.ready, v_r[0], "accepted item missing from first stage")
  `TFMM_AST_NOW(a_pipe_flows, out_chan.ready, in_chan.ready, "pipe blocked while receiver is ready")
  `TFMM_AST_NEXT(a_scale_write, psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_SCALE), cfg.scale == $past(pwdata), "scale register write lost")

endmodule
`default_nettype wire

>>> src/tfmm_cfg.sv
// APB register file with the registered scale times squish product
`default_nettype none
module tfmm_cfg import tfmm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  s32_t scale_r, squish_r, cx_r, cy_r, cz_r, sz_r;
  logic        wr_en;
  reg_idx_t    idx;
  logic signed [63:0] sz_prod;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 32'sd1 <<< FRAC_BITS;
      squish_r <= 32'sd1 <<< FRAC_BITS;
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SCALE:  scale_r  <= pwdata;
        REG_SQUISH: squish_r <= pwdata;
        REG_CX:     cx_r     <= pwdata;
        REG_CY:     cy_r     <= pwdata;
        REG_CZ:     cz_r     <= pwdata;
        default: ;
      endcase
    end
  end

  assign sz_prod = 64'(scale_r) * 64'(squish_r);

  always_ff @(posedge clk) begin
    sz_r <= sat32(SAT_W'(sz_prod >>> FRAC_BITS));
  end

  always_comb begin
    unique case (idx)
      REG_SCALE:  prdata = scale_r;
      REG_SQUISH: prdata = squish_r;
      REG_CX:     prdata = cx_r;
      REG_CY:     prdata = cy_r;
      REG_CZ:     prdata = cz_r;
      default:    prdata = '0;
    endcase
  end

  assign cfg = '{scale: scale_r, sz: sz_r, cx: cx_r, cy: cy_r, cz: cz_r};

endmodule
`default_nettype wire

>>> tb/sv/tangent_frame_model_matrix_core_checker.sv
// Checker: predicts each model matrix and compares it with the result channel
`timescale 1ns / 1ps
module tangent_frame_model_matrix_core_checker import tfmm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               fail_count,
  output int               outstanding,
  output int               matrices_seen
);

  localparam int FRAC = FRAC_BITS;
  localparam longint UP_LIMIT = ((longint'(95) << FRAC) + 50) / 100;

  string field_name [12] = '{"m_r0_c0", "m_r0_c1", "m_r0_c2", "m_r0_c3",
                             "m_r1_c0", "m_r1_c1", "m_r1_c2", "m_r1_c3",
                             "m_r2_c0", "m_r2_c1", "m_r2_c2", "m_r2_c3"};

  s32_t scale_r, squish_r, cx_r, cy_r, cz_r;
  out_item_t matrix_q[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp32((a * b) >>> FRAC);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_comp(longint a, longint unsigned len);
    longint unsigned mag;
    longint q;
    if (len == 0) return 0;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    q = longint'((mag << FRAC) / len);
    return (a < 0) ? -q : q;
  endfunction

  function automatic out_item_t frame_matrix(in_item_t it);
    longint p[3], t[3], c[3], cr[3], r[3], u[3], m[3][3];
    longint s, sz, a, b, lc;
    longint unsigned len;
    logic [383:0] vec;
    p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
    t[0] = it.tan_x; t[1] = it.tan_y; t[2] = it.tan_z;
    c[0] = cx_r; c[1] = cy_r; c[2] = cz_r;
    s = scale_r;
    sz = qmul(s, longint'(squish_r));
    // steep tangent switches the up vector to +X
    if (((t[1] < 0) ? -t[1] : t[1]) > UP_LIMIT) begin
      cr[0] = 0; cr[1] = -t[2]; cr[2] = t[1];
      a = cr[1]; b = cr[2];
    end else begin
      cr[0] = t[2]; cr[1] = 0; cr[2] = -t[0];
      a = cr[0]; b = cr[2];
    end
    len = root64(longint'(a * a) + longint'(b * b));
    for (int i = 0; i < 3; i++) r[i] = unit_comp(cr[i], len);
    u[0] = clamp32((t[1] * r[2] - t[2] * r[1]) >>> FRAC);
    u[1] = clamp32((t[2] * r[0] - t[0] * r[2]) >>> FRAC);
    u[2] = clamp32((t[0] * r[1] - t[1] * r[0]) >>> FRAC);
    for (int i = 0; i < 3; i++) begin
      m[i][0] = qmul(s, r[i]);
      m[i][1] = qmul(s, u[i]);
      m[i][2] = qmul(sz, t[i]);
    end
    for (int i = 0; i < 3; i++) begin
      lc = ((m[i][0] * c[0]) >>> FRAC) + ((m[i][1] * c[1]) >>> FRAC)
         + ((m[i][2] * c[2]) >>> FRAC);
      vec[383 - 128*i -: 32] = m[i][0][31:0];
      vec[351 - 128*i -: 32] = m[i][1][31:0];
      vec[319 - 128*i -: 32] = m[i][2][31:0];
      vec[287 - 128*i -: 32] = 32'(clamp32(p[i] - lc));
    end
    return out_item_t'(vec);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [383:0] got_v, want_v;
    if (!rst_n) begin
      scale_r  <= 32'sh0001_0000;
      squish_r <= 32'sh0001_0000;
      cx_r <= 0; cy_r <= 0; cz_r <= 0;
      matrix_q.delete();
      fail_count = 0;
      outstanding <= 0;
      matrices_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SCALE:  scale_r  <= pwdata;
          REG_SQUISH: squish_r <= pwdata;
          REG_CX:     cx_r <= pwdata;
          REG_CY:     cy_r <= pwdata;
          REG_CZ:     cz_r <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) matrix_q = {matrix_q, frame_matrix(in_data)};
      if (out_valid && out_ready) begin
        matrices_seen <= matrices_seen + 1;
        if (matrix_q.size() == 0) begin
          $display("mismatch %0t: result transfer with nothing expected", $realtime);
          fail_count++;
        end else begin
          got_v = out_data;
          want_v = matrix_q.pop_front();
          for (int k = 0; k < 12; k++)
            if (got_v[383 - 32*k -: 32] !== want_v[383 - 32*k -: 32])
              report(field_name[k], got_v[383 - 32*k -: 32], want_v[383 - 32*k -: 32]);
        end
      end
      outstanding <= matrix_q.size();
    end
  end

endmodule

>>> tb/sv/tangent_frame_model_matrix_core_test.sv
// Top of the tangent frame matrix testbench: stimulus, config writes, verdict
`timescale 1ns / 1ps
module tangent_frame_model_matrix_core_test import tfmm_pkg::*; ();

  localparam logic [2:0] UNUSED_IDX = 3'd7;
  localparam int LATENCY = 57;
  localparam int CYCLE_LIMIT = 300000;
  localparam s32_t ONE = 32'sh0001_0000;
  localparam s32_t MAXV = 32'sh7fff_ffff;
  localparam s32_t MINV = 32'sh8000_0000;
  localparam s32_t THR = s32_t'(((95 << FRAC_BITS) + 50) / 100);

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, outstanding, matrices_seen, cycles, items_sent;
  int src_idle, snk_idle;

  tfmm_in_if  in_if();
  tfmm_out_if out_if();

  tangent_frame_model_matrix_core u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if.sink), .out_chan(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tangent_frame_model_matrix_core_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_data(in_if.data),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .outstanding(outstanding), .matrices_seen(matrices_seen)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tangent_frame_model_matrix_core_test: errors");
      $finish;
    end
  end

  always @(negedge clk) out_if.ready <= ($urandom_range(99) >= snk_idle);

  task automatic send(in_item_t it);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(s32_t px, s32_t py, s32_t pz, s32_t tx, s32_t ty, s32_t tz);
    in_item_t it;
    it = '{px, py, pz, tx, ty, tz};
    send(it);
  endtask

  task automatic cfg_write(logic [2:0] idx, s32_t val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drain the pipe before touching registers
  task automatic settle();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic s32_t rnd_word(int kind);
    case (kind)
      0: return $urandom;
      1: return s32_t'($urandom_range(0, 8 * 65536)) - 4 * 65536;
      2: return s32_t'($urandom_range(0, 255)) - 128;
      default: return $urandom_range(0, 1) ? MAXV : MINV;
    endcase
  endfunction

  function automatic s32_t rnd_cfg();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? MAXV : MINV;
      2: return 0;
      default: return s32_t'($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  task automatic random_frame();
    s32_t px, py, pz, tx, ty, tz;
    int sel;
    sel = $urandom_range(0, 9);
    px = rnd_word($urandom_range(0, 1) ? 0 : 1);
    py = rnd_word($urandom_range(0, 1) ? 0 : 1);
    pz = rnd_word($urandom_range(0, 1) ? 0 : 1);
    tx = rnd_word(sel < 3 ? 0 : 1);
    ty = rnd_word(sel < 3 ? 0 : 1);
    tz = rnd_word(sel < 3 ? 0 : 1);
    case (sel)
      3: ty = THR + s32_t'($urandom_range(0, 4)) - 2;          // around the up switch
      4: ty = -THR + s32_t'($urandom_range(0, 4)) - 2;
      5: begin tx = 0; tz = 0; ty = rnd_word(2); end          // degenerate cross
      6: begin tx = rnd_word(3); tz = rnd_word(3); end
      default: ;
    endcase
    send_frame(px, py, pz, tx, ty, tz);
  endtask

  initial begin
    s32_t v[5];
    cycles = 0; items_sent = 0;
    src_idle = 0; snk_idle = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.data = '0; out_if.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames at reset config
    send_frame(0, 0, 0, 0, 0, 0);
    send_frame(ONE, ONE, ONE, ONE, 0, 0);
    send_frame(0, 0, 0, 0, 0, ONE);
    send_frame(0, 0, 0, 0, ONE, 0);
    send_frame(0, 0, 0, 0, THR, ONE);
    send_frame(0, 0, 0, ONE, THR + 1, ONE);
    send_frame(0, 0, 0, ONE, -THR, ONE);
    send_frame(0, 0, 0, ONE, -THR - 1, ONE);
    send_frame(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    send_frame(MINV, MINV, MINV, MINV, MINV, MINV);
    send_frame(MAXV, MINV, MAXV, MINV, 0, MAXV);
    send_frame(MINV, MAXV, MINV, 0, 0, 0);
    send_frame(-ONE, ONE, -ONE, 0, ONE / 2, 0);
    send_frame(ONE, 2 * ONE, 3 * ONE, 3 * ONE, ONE, -4 * ONE);
    send_frame(-1, -1, -1, -1, -1, -1);
    send_frame(1, 1, 1, 1, 1, 1);
    send_frame(0, 0, 0, MINV, MAXV, MINV);
    settle();
    cfg_write(UNUSED_IDX, 32'h1234_5678);
    send_frame(ONE, ONE, ONE, ONE, 0, ONE);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      src_idle = (ph / 2 == 0) ? 17 : (ph / 2 == 1) ? 77 : 0;
      snk_idle = (ph / 2 == 0) ? 77 : (ph / 2 == 1) ? 17 : 0;
      for (int k = 0; k < 5; k++)
        v[k] = (ph == 1) ? MAXV : (ph == 3) ? MINV : rnd_cfg();
      if (ph == 4) begin v[0] = ONE; v[1] = ONE; end
      cfg_write(REG_SCALE, v[0]);
      cfg_write(REG_SQUISH, v[1]);
      cfg_write(REG_CX, v[2]);
      cfg_write(REG_CY, v[3]);
      cfg_write(REG_CZ, v[4]);
      repeat (265) random_frame();
      settle();
    end

    $display("sent %0d frames, %0d matrices checked over six register settings",
             items_sent, matrices_seen);
    $display("idle mixes: sender-light, receiver-light and back to back");
    if (fail_count == 0 && outstanding == 0) begin
      $display("tangent_frame_model_matrix_core_test: clean");
    end else begin
      $display("tangent_frame_model_matrix_core_test: errors");
    end
    $finish;
  end

endmodule
